[rtl/core/msblit_pkg.sv]
// shared types and constants for the masked sprite blit unit
package msblit_pkg;

  // default frame geometry and sprite size cap
  localparam int FRAME_WIDTH_DEF    = 320;
  localparam int FRAME_HEIGHT_DEF   = 195;
  localparam int MAX_SPRITE_DIM_DEF = 255;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // destination row and column: 10-bit origin plus 8-bit offset
  localparam int POS_W = 11;

  // front to back queue
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ORIGIN_X      = 3'd0,
    REG_ORIGIN_Y      = 3'd1,
    REG_SPRITE_WIDTH  = 3'd2,
    REG_SPRITE_HEIGHT = 3'd3,
    REG_MIRROR        = 3'd4,
    REG_KEY_COLOR     = 3'd5,
    REG_INK_COLOR     = 3'd6
  } cfg_reg_e;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_PIXEL = 1'b1
  } op_e;

  // classified word handed from front to back
  typedef struct packed {
    op_e              kind;
    logic             load_ok;
    logic [12:0]      mask_idx;
    logic [7:0]       mask_byte;
    logic [POS_W-1:0] drow;
    logic [POS_W-1:0] dcol;
    logic             in_frame;
    logic             draw;
    logic             ink;
    logic             last;
  } msblit_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } msblit_qstat_t;

endpackage

[rtl/core/msblit_front.sv]
// front end: configuration registers, source position counters, word classification
module msblit_front import msblit_pkg::*; #(
  parameter int FRAME_WIDTH    = FRAME_WIDTH_DEF,
  parameter int FRAME_HEIGHT   = FRAME_HEIGHT_DEF,
  parameter int MAX_SPRITE_DIM = MAX_SPRITE_DIM_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  opcode_i,
  input  logic [12:0]           mask_index_i,
  input  logic [7:0]            mask_byte_i,
  input  logic [15:0]           pixel_color_i,
  input  logic                  accept_i,
  output msblit_item_t          item_o
);

  localparam int MASK_BYTES = (FRAME_WIDTH * FRAME_HEIGHT + 7) / 8;
  localparam logic [7:0] DIM_CAP =
    (MAX_SPRITE_DIM > 255) ? 8'd255 : 8'(MAX_SPRITE_DIM);
  localparam logic [POS_W-1:0] FW_L = POS_W'(FRAME_WIDTH);
  localparam logic [POS_W-1:0] FH_L = POS_W'(FRAME_HEIGHT);

  logic [9:0]  origin_x_q, origin_y_q;
  logic [7:0]  sprite_width_q, sprite_height_q;
  logic        mirror_q;
  logic [15:0] key_color_q, ink_color_q;
  logic [7:0]  col_q, col_d, row_q, row_d;

  logic [7:0]       w_eff, h_eff, col, row, mcol;
  logic             restart, col_end, row_end;
  logic [POS_W-1:0] dcol, drow;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_x_q      <= '0;
      origin_y_q      <= '0;
      sprite_width_q  <= 8'd1;
      sprite_height_q <= 8'd1;
      mirror_q        <= 1'b0;
      key_color_q     <= '0;
      ink_color_q     <= 16'd1;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_ORIGIN_X:      origin_x_q      <= cfg_data_i[9:0];
        REG_ORIGIN_Y:      origin_y_q      <= cfg_data_i[9:0];
        REG_SPRITE_WIDTH:  sprite_width_q  <= cfg_data_i[7:0];
        REG_SPRITE_HEIGHT: sprite_height_q <= cfg_data_i[7:0];
        REG_MIRROR:        mirror_q        <= cfg_data_i[0];
        REG_KEY_COLOR:     key_color_q     <= cfg_data_i;
        REG_INK_COLOR:     ink_color_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // effective sprite size: zero acts as one, cap at the maximum
  always_comb begin
    w_eff = (sprite_width_q == 8'd0) ? 8'd1 :
            (sprite_width_q > DIM_CAP) ? DIM_CAP : sprite_width_q;
    h_eff = (sprite_height_q == 8'd0) ? 8'd1 :
            (sprite_height_q > DIM_CAP) ? DIM_CAP : sprite_height_q;
  end

  always_comb begin
    // counters left outside a resized sprite restart at the top left
    restart = (col_q >= w_eff) || (row_q >= h_eff);
    col     = restart ? 8'd0 : col_q;
    row     = restart ? 8'd0 : row_q;
    col_end = (col == w_eff - 8'd1);
    row_end = (row == h_eff - 8'd1);
    mcol    = mirror_q ? (w_eff - 8'd1 - col) : col;
    dcol    = POS_W'(origin_x_q) + POS_W'(mcol);
    drow    = POS_W'(origin_y_q) + POS_W'(row);
  end

  always_comb begin
    col_d = col_end ? 8'd0 : col + 8'd1;
    row_d = col_end ? (row_end ? 8'd0 : row + 8'd1) : row;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept_i && (op_e'(opcode_i) == OP_PIXEL)) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  always_comb begin
    item_o.kind      = op_e'(opcode_i);
    item_o.load_ok   = 32'(mask_index_i) < 32'(MASK_BYTES);
    item_o.mask_idx  = mask_index_i;
    item_o.mask_byte = mask_byte_i;
    item_o.drow      = drow;
    item_o.dcol      = dcol;
    item_o.in_frame  = (dcol < FW_L) && (drow < FH_L);
    item_o.draw      = pixel_color_i != key_color_q;
    item_o.ink       = pixel_color_i == ink_color_q;
    item_o.last      = col_end && row_end;
  end

endmodule

[rtl/core/msblit_queue.sv]
// short fifo of classified words between front and back
module msblit_queue import msblit_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  msblit_item_t  item_i,
  input  logic          pop_i,
  output msblit_item_t  item_o,
  output msblit_qstat_t stat_o
);

  msblit_item_t    entry_q [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [Q_AW:0]   cnt_q, cnt_d;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= item_i;
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      cnt_q <= cnt_d;
    end
  end

  assign item_o       = entry_q[rd_ptr_q];
  assign stat_o.full  = cnt_q == (Q_AW + 1)'(Q_DEPTH);
  assign stat_o.empty = cnt_q == '0;

endmodule

[rtl/core/msblit_back.sv]
// back end: address multiply, redraw mask memory, result register
module msblit_back import msblit_pkg::*; #(
  parameter int FRAME_WIDTH  = FRAME_WIDTH_DEF,
  parameter int FRAME_HEIGHT = FRAME_HEIGHT_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  msblit_item_t  item_i,
  input  msblit_qstat_t qstat_i,
  output logic          pop_o,
  output logic          clr_busy_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic          write_enable_o,
  output logic [15:0]   bit_address_o,
  output logic          bit_value_o,
  output logic          last_pixel_o
);

  localparam int MASK_BYTES = (FRAME_WIDTH * FRAME_HEIGHT + 7) / 8;
  localparam int MEM_AW     = (MASK_BYTES > 1) ? $clog2(MASK_BYTES) : 1;
  localparam int ADDR_W     = 2 * POS_W;
  localparam logic [MEM_AW-1:0] LAST_IDX = MEM_AW'(MASK_BYTES - 1);

  logic [7:0] mask_mem [MASK_BYTES];
  logic [7:0] rdata_q;

  logic              adv;
  logic [ADDR_W-1:0] addr_d;

  logic              s1_v_q;
  msblit_item_t      s1_q;
  logic [ADDR_W-1:0] s1_addr_q;

  logic        s2_v_q, s2_pix_q, s2_in_frame_q, s2_draw_q, s2_ink_q, s2_last_q;
  logic [2:0]  s2_bit_q;
  logic [15:0] s2_addr_q;

  logic        out_valid_q, out_we_q, out_val_q, out_last_q;
  logic [15:0] out_addr_q;

  logic              clr_busy_q;
  logic [MEM_AW-1:0] clr_idx_q;

  logic              mem_we, mem_re, s2_hit;
  logic [MEM_AW-1:0] mem_widx, mem_ridx;
  logic [7:0]        mem_wdata;

  // the whole back end moves when the result register is free or drained
  assign adv   = !out_valid_q || out_ready_i;
  assign pop_o = adv && !qstat_i.empty;

  // frame bit index of the queue head
  assign addr_d = ADDR_W'(item_i.drow) * ADDR_W'(FRAME_WIDTH) + ADDR_W'(item_i.dcol);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else if (adv) begin
      s1_v_q <= !qstat_i.empty;
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_q          <= item_i;
      s1_addr_q     <= addr_d;
      s2_pix_q      <= s1_q.kind == OP_PIXEL;
      s2_in_frame_q <= s1_q.in_frame;
      s2_draw_q     <= s1_q.draw;
      s2_ink_q      <= s1_q.ink;
      s2_last_q     <= s1_q.last;
      s2_bit_q      <= s1_addr_q[2:0];
      s2_addr_q     <= s1_addr_q[15:0];
    end
  end

  // clearing pass after reset, one byte a cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_idx_q  <= '0;
    end else if (clr_busy_q) begin
      clr_idx_q <= clr_idx_q + 1'b1;
      if (clr_idx_q == LAST_IDX) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  always_comb begin
    mem_we    = clr_busy_q ||
                (adv && s1_v_q && (s1_q.kind == OP_LOAD) && s1_q.load_ok);
    mem_widx  = clr_busy_q ? clr_idx_q : MEM_AW'(s1_q.mask_idx);
    mem_wdata = clr_busy_q ? 8'd0 : s1_q.mask_byte;
    mem_re    = adv && s1_v_q && (s1_q.kind == OP_PIXEL) && s1_q.in_frame;
    mem_ridx  = MEM_AW'(s1_addr_q >> 3);
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mask_mem[mem_widx] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mask_mem[mem_ridx];
    end
  end

  assign s2_hit = s2_in_frame_q && s2_draw_q && rdata_q[s2_bit_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= s2_v_q && s2_pix_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_we_q   <= s2_hit;
      out_addr_q <= s2_hit ? s2_addr_q : 16'd0;
      out_val_q  <= s2_hit && s2_ink_q;
      out_last_q <= s2_last_q;
    end
  end

  assign clr_busy_o     = clr_busy_q;
  assign out_valid_o    = out_valid_q;
  assign write_enable_o = out_we_q;
  assign bit_address_o  = out_addr_q;
  assign bit_value_o    = out_val_q;
  assign last_pixel_o   = out_last_q;

endmodule

[rtl/core/masked_sprite_blit_to_bitmap_unit.sv]
// top level of the masked sprite blit unit
//
// blits a 16-bit color sprite into a 1-bit frame bitmap kept outside the
// block. load words (opcode 0) write one byte of the internal redraw mask;
// pixel words (opcode 1) arrive in source raster order and each gives one
// result word saying whether, where (row*FRAME_WIDTH+column, low 16 bits)
// and with what value the external bitmap bit is written. a pixel is dropped
// when it lands outside the frame, its redraw mask bit is clear or it
// matches key_color; it writes 1 for ink_color and 0 for any other color.
// mirror flips the destination column. while the result port is not stalled
// the block takes one word and gives one result per clock in steady state; a
// pixel's result goes from the queue, written at the accepting edge, through
// address multiply, mask memory read and result register. after reset the
// redraw mask is cleared one byte per cycle, (FRAME_WIDTH*FRAME_HEIGHT+7)/8
// bytes (7800 at the default frame), and in_ready_o stays low until that
// pass ends; configuration writes are taken throughout. configuration is to
// be written by the user only while idle; the block does not enforce it.
module masked_sprite_blit_to_bitmap_unit import msblit_pkg::*; #(
  parameter int FRAME_WIDTH    = FRAME_WIDTH_DEF,
  parameter int FRAME_HEIGHT   = FRAME_HEIGHT_DEF,
  parameter int MAX_SPRITE_DIM = MAX_SPRITE_DIM_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration write port
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // input words
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  opcode_i,
  input  logic [12:0]           mask_index_i,
  input  logic [7:0]            mask_byte_i,
  input  logic [15:0]           pixel_color_i,
  // result words
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  write_enable_o,
  output logic [15:0]           bit_address_o,
  output logic                  bit_value_o,
  output logic                  last_pixel_o
);

  msblit_item_t  front_item, head_item;
  msblit_qstat_t q_stat;
  logic          push, pop, clr_busy;

  // no words while the mask is being cleared or the queue is full
  assign in_ready_o = !clr_busy && !q_stat.full;
  assign push       = in_valid_i && in_ready_o;

  // front: config registers, position counters, clip and color tests
  msblit_front #(
    .FRAME_WIDTH    (FRAME_WIDTH),
    .FRAME_HEIGHT   (FRAME_HEIGHT),
    .MAX_SPRITE_DIM (MAX_SPRITE_DIM)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .opcode_i      (opcode_i),
    .mask_index_i  (mask_index_i),
    .mask_byte_i   (mask_byte_i),
    .pixel_color_i (pixel_color_i),
    .accept_i      (push),
    .item_o        (front_item)
  );

  // decouples the front from a stalled result port
  msblit_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (front_item),
    .pop_i  (pop),
    .item_o (head_item),
    .stat_o (q_stat)
  );

  // back: bit address, mask lookup and result register
  msblit_back #(
    .FRAME_WIDTH  (FRAME_WIDTH),
    .FRAME_HEIGHT (FRAME_HEIGHT)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_i         (head_item),
    .qstat_i        (q_stat),
    .pop_o          (pop),
    .clr_busy_o     (clr_busy),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .write_enable_o (write_enable_o),
    .bit_address_o  (bit_address_o),
    .bit_value_o    (bit_value_o),
    .last_pixel_o   (last_pixel_o)
  );

  // the queue never takes a word while full
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_stat.full)
    else $error("queue push while full");

  // the queue never gives a word while empty
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_stat.empty)
    else $error("queue pop while empty");

  // once the mask clear finishes it never restarts
  a_clear_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !clr_busy |=> !clr_busy)
    else $error("mask clear restarted");

  // a result with no write carries zero address and value
  a_idle_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !write_enable_o) |-> (bit_address_o == '0 && !bit_value_o))
    else $error("nonzero fields on a result with no write");

endmodule
